@@ hw/rtl/wcmc_pkg.sv @@
// types and constants shared by the colour math compositor
`timescale 1ns / 1ps
package wcmc_pkg;

  localparam int XW = 10;
  localparam int CW = 16;
  localparam int RW = 5;
  localparam int GW = 6;
  localparam int BW = 5;
  localparam int IDXW = 2;
  localparam int DATW = 2;

  typedef enum logic [1:0] {
    MIX_ADD      = 2'd0,
    MIX_ADD_HALF = 2'd1,
    MIX_SUB      = 2'd2,
    MIX_SUB_HALF = 2'd3
  } cm_op_t;

  typedef enum logic [IDXW-1:0] {
    CFG_MATH_OP   = 2'd0,
    CFG_FIXED_SRC = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [XW-1:0] pixel_x;
    logic [XW-1:0] window_left;
    logic [XW-1:0] window_right;
    logic [CW-1:0] main_colour;
    logic [CW-1:0] layer_colour;
    logic [CW-1:0] line_fixed_colour;
  } pixel_t;

  typedef struct packed {
    logic [CW-1:0] out_colour;
    logic          inside_window;
  } result_t;

endpackage

@@ hw/rtl/wcmc_chan.sv @@
// one colour channel: saturating add, halved add, clamped subtract, subtract half
`timescale 1ns / 1ps
module wcmc_chan #(
  parameter int W = 5
) (
  input  wcmc_pkg::cm_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y
);
  import wcmc_pkg::*;

  logic [W:0]   sum;
  logic [W-1:0] b_half;

  assign sum    = {1'b0, a} + {1'b0, b};
  assign b_half = {1'b0, b[W-1:1]};

  always_comb begin
    case (op)
      MIX_ADD:      y = sum[W] ? {W{1'b1}} : sum[W-1:0];
      MIX_ADD_HALF: y = sum[W:1];
      MIX_SUB:      y = (a > b) ? (a - b) : '0;
      MIX_SUB_HALF: y = (a > b_half) ? (a - b_half) : '0;
      default:      y = a;
    endcase
  end

endmodule

@@ hw/rtl/wcmc_core.sv @@
// window test, subscreen source select and per-channel colour math
`timescale 1ns / 1ps
module wcmc_core (
  input  wcmc_pkg::pixel_t  pix,
  input  wcmc_pkg::cm_op_t  op,
  input  logic              fixed_src,
  output wcmc_pkg::result_t res
);
  import wcmc_pkg::*;

  logic          in_window;
  logic [CW-1:0] sub_c;
  logic [CW-1:0] mixed;

  assign in_window = (pix.window_right > pix.window_left) &&
                     (pix.pixel_x >= pix.window_left) &&
                     (pix.pixel_x < pix.window_right);
  assign sub_c  = fixed_src ? pix.line_fixed_colour : pix.layer_colour;

  wcmc_chan #(.W(RW)) u_red (
    .op(op),
    .a (pix.main_colour[CW-1 -: RW]),
    .b (sub_c[CW-1 -: RW]),
    .y (mixed[CW-1 -: RW])
  );

  wcmc_chan #(.W(GW)) u_green (
    .op(op),
    .a (pix.main_colour[BW +: GW]),
    .b (sub_c[BW +: GW]),
    .y (mixed[BW +: GW])
  );

  wcmc_chan #(.W(BW)) u_blue (
    .op(op),
    .a (pix.main_colour[BW-1:0]),
    .b (sub_c[BW-1:0]),
    .y (mixed[BW-1:0])
  );

  assign res.out_colour    = in_window ? mixed : pix.main_colour;
  assign res.inside_window = in_window;

endmodule

@@ hw/rtl/windowed_colour_math_compositor.sv @@
// the accepting edge loads the input reg; the result reg loads from it once it is empty or not stalled
// throughput: one pixel per cycle, limited only by the result side stalling
// while a finished result waits the input register takes one more request, then stalls
// reset: synchronous, clears both stage valids, math_op to add-half, fixed select off
// config writes always ready, index 0 math_op, index 1 fixed colour select
`timescale 1ns / 1ps
module windowed_colour_math_compositor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wcmc_pkg::IDXW-1:0]   cfg_index,
  input  logic [wcmc_pkg::DATW-1:0]   cfg_data,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  logic [wcmc_pkg::XW-1:0]     pixel_x,
  input  logic [wcmc_pkg::XW-1:0]     window_left,
  input  logic [wcmc_pkg::XW-1:0]     window_right,
  input  logic [wcmc_pkg::CW-1:0]     main_colour,
  input  logic [wcmc_pkg::CW-1:0]     layer_colour,
  input  logic [wcmc_pkg::CW-1:0]     line_fixed_colour,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [wcmc_pkg::CW-1:0]     out_colour,
  output logic                        inside_window
);
  import wcmc_pkg::*;

  cm_op_t  math_op;
  logic    fixed_src;
  logic    s1_valid;
  pixel_t  s1_pix;
  logic    s2_valid;
  result_t s2_res;
  result_t core_res;
  logic    s2_load;
  logic    s1_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      math_op   <= MIX_ADD_HALF;
      fixed_src <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MATH_OP:   math_op   <= cm_op_t'(cfg_data);
        CFG_FIXED_SRC: fixed_src <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s2_load     = s1_valid && (!s2_valid || !result_stall);
  assign s1_load     = pixel_valid && !pixel_stall;
  assign pixel_stall = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix.pixel_x           <= pixel_x;
      s1_pix.window_left       <= window_left;
      s1_pix.window_right      <= window_right;
      s1_pix.main_colour       <= main_colour;
      s1_pix.layer_colour      <= layer_colour;
      s1_pix.line_fixed_colour <= line_fixed_colour;
    end
  end

  wcmc_core u_core (
    .pix      (s1_pix),
    .op       (math_op),
    .fixed_src(fixed_src),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (!result_stall) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_res <= core_res;
    end
  end

  assign result_valid  = s2_valid;
  assign out_colour    = s2_res.out_colour;
  assign inside_window = s2_res.inside_window;

  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted request did not reach the input register");

  a_s1_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> (s1_valid && $stable(s1_pix)))
    else $error("input register lost a waiting request");

  a_load_gives_result : assert property (@(posedge clk) disable iff (rst)
    s2_load |=> result_valid)
    else $error("result register not filled after load");

  a_outside_passes_main : assert property (@(posedge clk) disable iff (rst)
    (s2_load && !core_res.inside_window) |=>
      (out_colour == $past(s1_pix.main_colour)))
    else $error("pixel outside the window was not passed through");

endmodule

@@ test/windowed_colour_math_compositor_tb.sv @@
// testbench for the windowed colour math compositor: random and directed pixels, scoreboard
`timescale 1ns / 1ps
module windowed_colour_math_compositor_tb;
  import wcmc_pkg::*;

  localparam logic [IDXW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [IDXW-1:0] CFG_SPARE_B = 2'd3;
  localparam int RMAX = (1 << RW) - 1;
  localparam int GMAX = (1 << GW) - 1;
  localparam int BMAX = (1 << BW) - 1;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDXW-1:0] cfg_index;
  logic [DATW-1:0] cfg_data;
  logic pixel_valid;
  logic pixel_stall;
  logic [XW-1:0] pixel_x;
  logic [XW-1:0] window_left;
  logic [XW-1:0] window_right;
  logic [CW-1:0] main_colour;
  logic [CW-1:0] layer_colour;
  logic [CW-1:0] line_fixed_colour;
  logic result_valid;
  logic result_stall;
  logic [CW-1:0] out_colour;
  logic inside_window;

  pixel_t pixels_to_send[$];
  result_t composites_due[$];
  int pixels_queued;
  int pixels_accepted;
  int error_count;
  logic pixel_taken;
  cm_op_t op_now;
  logic fixed_now;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_run;

  windowed_colour_math_compositor uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_x(pixel_x),
    .window_left(window_left),
    .window_right(window_right),
    .main_colour(main_colour),
    .layer_colour(layer_colour),
    .line_fixed_colour(line_fixed_colour),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_colour(out_colour),
    .inside_window(inside_window)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int blend_channel(int a, int b, int top, cm_op_t op);
    int v;
    case (op)
      MIX_ADD: v = (a + b > top) ? top : a + b;
      MIX_ADD_HALF: v = (a + b) >> 1;
      MIX_SUB: v = (a > b) ? a - b : 0;
      default: v = (a > (b >> 1)) ? a - (b >> 1) : 0;
    endcase
    return v;
  endfunction

  function automatic result_t blend_pixel(pixel_t p, cm_op_t op, logic fixed_sel);
    result_t r;
    logic [CW-1:0] s;
    logic [CW-1:0] m;
    m = p.main_colour;
    s = fixed_sel ? p.line_fixed_colour : p.layer_colour;
    r.inside_window = (p.window_right > p.window_left) && (p.pixel_x >= p.window_left) &&
                      (p.pixel_x < p.window_right);
    if (r.inside_window) begin
      r.out_colour = {RW'(blend_channel(int'(m[15:11]), int'(s[15:11]), RMAX, op)),
                      GW'(blend_channel(int'(m[10:5]), int'(s[10:5]), GMAX, op)),
                      BW'(blend_channel(int'(m[4:0]), int'(s[4:0]), BMAX, op))};
    end else begin
      r.out_colour = m;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] pick_colour();
    logic [CW-1:0] c;
    case ($urandom_range(0, 5))
      0: c = '0;
      1: c = '1;
      2: c = {($urandom_range(0, 1) ? 5'h1f : 5'h00), ($urandom_range(0, 1) ? 6'h3f : 6'h00),
              ($urandom_range(0, 1) ? 5'h1f : 5'h00)};
      default: c = CW'($urandom);
    endcase
    return c;
  endfunction

  task automatic queue_pixel(int x, int l, int r, logic [CW-1:0] m, logic [CW-1:0] ly,
                             logic [CW-1:0] f);
    pixel_t p;
    p.pixel_x = XW'(x);
    p.window_left = XW'(l);
    p.window_right = XW'(r);
    p.main_colour = m;
    p.layer_colour = ly;
    p.line_fixed_colour = f;
    pixels_to_send.push_back(p);
    pixels_queued++;
  endtask

  // mostly real windows with columns near the edges, some empty or inverted lines
  task automatic queue_random_pixel();
    int l;
    int r;
    int x;
    int kind;
    kind = $urandom_range(0, 9);
    l = $urandom_range(0, 1022);
    r = $urandom_range(l + 1, 1023);
    if (kind == 8) begin
      r = l;
    end else if (kind == 9) begin
      r = $urandom_range(0, l);
    end
    case ($urandom_range(0, 6))
      0: x = l;
      1: x = (r > 0) ? r - 1 : 0;
      2: x = r;
      3: x = (l > 0) ? l - 1 : 0;
      4: x = $urandom_range(0, 1023);
      default: x = (r > l) ? $urandom_range(l, r - 1) : $urandom_range(0, 1023);
    endcase
    queue_pixel(x, l, r, pick_colour(), pick_colour(), pick_colour());
  endtask

  task automatic write_reg(logic [IDXW-1:0] idx, logic [DATW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MATH_OP) begin
      op_now = cm_op_t'(val);
    end else if (idx == CFG_FIXED_SRC) begin
      fixed_now = val[0];
    end
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pixels_accepted != pixels_queued || composites_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_directed(int seed);
    queue_pixel(0, 0, 1023, 16'hffff, 16'hffff, 16'hffff);
    queue_pixel(1022, 0, 1023, 16'h0000, 16'hffff, 16'hffff);
    queue_pixel(1023, 0, 1023, 16'hffff, 16'h0000, 16'h0000);
    queue_pixel(5, 5, 5, CW'(16'h1234 + seed), 16'hffff, 16'hffff);
    queue_pixel(600, 900, 100, 16'h8410, 16'hffff, 16'h0000);
    queue_pixel(300, 300, 301, CW'(16'h8410 ^ seed), 16'h7bef, 16'hf81f);
  endtask

  always @(negedge clk) begin : drive_pixels
    pixel_t nxt;
    logic nxt_valid;
    if (!rst && !(pixel_valid && !pixel_taken)) begin
      nxt_valid = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (burst_left > 0) begin
        if (pixels_to_send.size() > 0) begin
          nxt = pixels_to_send.pop_front();
          pixel_x <= nxt.pixel_x;
          window_left <= nxt.window_left;
          window_right <= nxt.window_right;
          main_colour <= nxt.main_colour;
          layer_colour <= nxt.layer_colour;
          line_fixed_colour <= nxt.line_fixed_colour;
          nxt_valid = 1'b1;
          burst_left--;
        end
      end else begin
        gap_left--;
      end
      pixel_valid <= nxt_valid;
    end
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(8, 60);
    end
    stall_run--;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    pixel_taken = 1'b0;
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        pixel_taken = 1'b1;
        pixels_accepted++;
        composites_due.push_back(blend_pixel(pixel_t'({pixel_x, window_left, window_right,
            main_colour, layer_colour, line_fixed_colour}), op_now, fixed_now));
      end
      if (result_valid && !result_stall) begin
        got.out_colour = out_colour;
        got.inside_window = inside_window;
        if (composites_due.size() == 0) begin
          $error("unexpected result out_colour=%h inside_window=%b", out_colour, inside_window);
          error_count++;
        end else begin
          want = composites_due.pop_front();
          if (got.out_colour !== want.out_colour) begin
            $error("out_colour expected %h actual %h", want.out_colour, got.out_colour);
            error_count++;
          end
          if (got.inside_window !== want.inside_window) begin
            $error("inside_window expected %b actual %b", want.inside_window,
                   got.inside_window);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_MATH_OP;
    cfg_data = '0;
    pixel_valid = 1'b0;
    pixel_x = '0;
    window_left = '0;
    window_right = '0;
    main_colour = '0;
    layer_colour = '0;
    line_fixed_colour = '0;
    result_stall = 1'b0;
    pixel_taken = 1'b0;
    pixels_queued = 0;
    pixels_accepted = 0;
    error_count = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_run = 0;
    op_now = MIX_ADD_HALF;
    fixed_now = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset settings first, then every operation
    queue_directed(0);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_MATH_OP, DATW'(i));
      write_reg(CFG_FIXED_SRC, DATW'(i % 2));
      end_writes();
      queue_directed(i + 1);
      wait_idle();
    end

    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_SPARE_A, DATW'($urandom));
        write_reg(CFG_SPARE_B, DATW'($urandom));
      end
      write_reg(CFG_MATH_OP, DATW'(ph % 4));
      write_reg(CFG_FIXED_SRC, {1'($urandom), 1'(ph / 4)});
      end_writes();
      repeat (88) queue_random_pixel();
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
